// ===== rtl/rstw_pkg.sv =====
// Shared types and constants of the reliable send window tracker.
// No dependencies; imported by the output stage, the top level and the test bench.
package rstw_pkg;

   // input item kinds
   localparam logic [1:0] KIND_PUSH = 2'd0;
   localparam logic [1:0] KIND_ACK  = 2'd1;
   localparam logic [1:0] KIND_NACK = 2'd2;
   localparam logic [1:0] KIND_TICK = 2'd3;

   // result events
   localparam logic [1:0] EV_SEND     = 2'd0;
   localparam logic [1:0] EV_RESEND   = 2'd1;
   localparam logic [1:0] EV_ACCEPTED = 2'd2;
   localparam logic [1:0] EV_WRITABLE = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_WINDOW_SIZE = 2'd0;
   localparam logic [1:0] CSR_NAGLE_EN    = 2'd1;
   localparam logic [1:0] CSR_NAGLE_DELAY = 2'd2;
   localparam logic [1:0] CSR_INIT_SEQ    = 2'd3;

   localparam logic [16:0] BUF_MAX      = 17'd131071;
   localparam int          SMALL_MARGIN = 256;
   localparam logic [7:0]  TRIES_MAX    = 8'd255;

   typedef struct packed {
      logic [1:0]  event_res;
      logic [31:0] out_seq;
      logic [10:0] segment_length;
      logic [7:0]  send_count;
      logic [15:0] accepted_bytes;
   } result_type;

endpackage

// ===== rtl/reliable_send_window_tracker.sv =====
// Top level of the reliable send window tracker: sequencer, state registers
// and segment stores. Depends on rstw_pkg, rstw_ram and rstw_out.
//
// Usage: items enter on the req_ stream (kind in tuser), results leave on the
// rsp_ stream (event in tuser, tlast on the final result of an item). An item
// with no result produces no transfer. Configuration is written on the csr_
// channel, always ready; the user must write it only while the block is idle,
// since the block itself does not enforce this. Writing initial_seq empties
// the pending and window stores and restarts the sequence numbers.
// One item at a time: req_tready is high only while the sequencer is idle.
// A push tops up the newest pending segment, cuts new segments until the
// bytes are taken, the pending store is full or the limit is passed, then
// sends; an ack frees window entries, resends a lone remaining entry and
// checks the limit, a stale ack does nothing; a nack resends a lost entry
// and a final entry runs the ack part; a tick sends and checks the limit.
// Each step goes through the one-read, one-write port of the pending or the
// window store, and the read data is registered.
// Reset is synchronous and clears the sequencer, the counters and the output
// stage; store contents are left undefined as they are only read when valid.
// When the receiver stalls, the output and hold registers fill and the
// sequencer waits; no result is lost.
module reliable_send_window_tracker #(
   parameter int SEGMENT_BYTES = 1024,
   parameter int WINDOW_DEPTH  = 32,
   parameter int PENDING_DEPTH = 64,
   parameter int DEFAULT_LIMIT = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,  // byte_count, seq_number, loss_offset, has_loss,
                                    // final_entry, now_ms
   input  logic [1:0]   req_tuser,  // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata,  // out_seq, segment_length, send_count, accepted_bytes
   output logic [1:0]   rsp_tuser,  // event_res
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);
   import rstw_pkg::*;

   localparam int PAW = PENDING_DEPTH > 1 ? $clog2(PENDING_DEPTH) : 1;
   localparam int PFW = $clog2(PENDING_DEPTH + 1);
   localparam int PSW = PAW + 1;
   localparam int WAW = WINDOW_DEPTH > 1 ? $clog2(WINDOW_DEPTH) : 1;
   localparam int WFW = $clog2(WINDOW_DEPTH + 1);
   localparam int WSW = WAW + 1;
   localparam logic [10:0] SEG_LEN   = 11'(SEGMENT_BYTES);
   localparam logic [10:0] SMALL_LEN = 11'(SEGMENT_BYTES - SMALL_MARGIN);

   // sequencer states
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_TOP_RD  = 4'd1;
   localparam logic [3:0] S_TOP     = 4'd2;
   localparam logic [3:0] S_CUT     = 4'd3;
   localparam logic [3:0] S_SUM     = 4'd4;
   localparam logic [3:0] S_SEND_RD = 4'd5;
   localparam logic [3:0] S_SEND    = 4'd6;
   localparam logic [3:0] S_ACC     = 4'd7;
   localparam logic [3:0] S_WRIT    = 4'd8;
   localparam logic [3:0] S_ACK_RD  = 4'd9;
   localparam logic [3:0] S_ACK_SUB = 4'd10;
   localparam logic [3:0] S_ACK_END = 4'd11;
   localparam logic [3:0] S_RES_RD  = 4'd12;
   localparam logic [3:0] S_RES     = 4'd13;
   localparam logic [3:0] S_FIN     = 4'd14;

   logic [3:0]  state_ff, state_in;
   logic [1:0]  kind_ff, kind_in;
   logic [15:0] bytes_ff, bytes_in;
   logic [31:0] seq_ff, seq_in;
   logic        final_ff, final_in;
   logic [31:0] now_ff, now_in;
   logic [15:0] taken_ff, taken_in;
   logic [31:0] next_seq_ff, next_seq_in;
   logic [31:0] sent_high_ff, sent_high_in;
   logic [31:0] base_ff, base_in;
   logic [16:0] buffered_ff, buffered_in;
   logic [16:0] limit_ff, limit_in;
   logic [PFW-1:0] pf_ff, pf_in;
   logic [PAW-1:0] ph_ff, ph_in;
   logic [WFW-1:0] wf_ff, wf_in;
   logic [WAW-1:0] wh_ff, wh_in;
   logic [WAW-1:0] res_rel_ff, res_rel_in;
   logic [5:0]  ws_ff, ws_in;
   logic        nagle_en_ff, nagle_en_in;
   logic [15:0] nagle_delay_ff, nagle_delay_in;

   // store ports
   logic           p_we;
   logic [PAW-1:0] p_waddr, p_raddr;
   logic [42:0]    p_wdata, p_rdata;
   logic           w_we;
   logic [WAW-1:0] w_waddr, w_raddr;
   logic [18:0]    w_wdata, w_rdata;

   // output stage
   logic       res_push, res_flush, res_ok;
   result_type res_data;

   // input fields
   logic [15:0] in_bytes, in_off;
   logic [31:0] in_seq, in_now;
   logic        in_loss, in_final;
   assign in_bytes = req_tdata[15:0];
   assign in_seq   = req_tdata[47:16];
   assign in_off   = req_tdata[63:48];
   assign in_loss  = req_tdata[64];
   assign in_final = req_tdata[65];
   assign in_now   = req_tdata[97:66];

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;

   // address helpers
   logic [PSW-1:0] p_tail_sum, p_last_sum;
   logic [PAW-1:0] p_tail, p_last, ph_next;
   logic [WSW-1:0] w_tail_sum;
   logic [WAW-1:0] w_tail, wh_next;
   assign p_tail_sum = PSW'(ph_ff) + PSW'(pf_ff);
   assign p_last_sum = p_tail_sum - PSW'(1);
   assign p_tail = (p_tail_sum >= PSW'(PENDING_DEPTH)) ?
                   PAW'(p_tail_sum - PSW'(PENDING_DEPTH)) : PAW'(p_tail_sum);
   assign p_last = (p_last_sum >= PSW'(PENDING_DEPTH)) ?
                   PAW'(p_last_sum - PSW'(PENDING_DEPTH)) : PAW'(p_last_sum);
   assign ph_next = (ph_ff == PAW'(PENDING_DEPTH - 1)) ? '0 : ph_ff + PAW'(1);
   assign w_tail_sum = WSW'(wh_ff) + WSW'(wf_ff);
   assign w_tail = (w_tail_sum >= WSW'(WINDOW_DEPTH)) ?
                   WAW'(w_tail_sum - WSW'(WINDOW_DEPTH)) : WAW'(w_tail_sum);
   assign wh_next = (wh_ff == WAW'(WINDOW_DEPTH - 1)) ? '0 : wh_ff + WAW'(1);

   // nack lookup at acceptance
   logic [31:0]    nack_idx;
   logic           nack_hit;
   logic [WSW-1:0] nack_sum;
   logic [WAW-1:0] res_addr;
   assign nack_idx = in_seq + 32'(in_off) - base_ff;
   assign nack_hit = in_loss && (nack_idx < 32'(wf_ff));
   assign nack_sum = WSW'(wh_ff) + WSW'(res_rel_ff);
   assign res_addr = (nack_sum >= WSW'(WINDOW_DEPTH)) ?
                     WAW'(nack_sum - WSW'(WINDOW_DEPTH)) : WAW'(nack_sum);

   // window room and segment move checks
   logic [6:0]  room;
   logic        can_move;
   logic [32:0] nagle_due;
   logic        nagle_hold;
   assign room = (7'(ws_ff) < 7'(WINDOW_DEPTH)) ? 7'(ws_ff) : 7'(WINDOW_DEPTH);
   assign can_move = (pf_ff != '0) && (7'(wf_ff) < room);
   assign nagle_due = 33'(p_rdata[42:11]) + 33'(nagle_delay_ff);
   assign nagle_hold = nagle_en_ff && (nagle_due > 33'(now_ff)) &&
                       (p_rdata[10:0] < SMALL_LEN);

   // byte arithmetic
   logic [15:0] top_room, top_c, cut_rest, cut_c, cut_taken;
   logic [17:0] cut_total, buf_sum;
   logic [16:0] grow, new_limit;
   logic [31:0] send_seq;
   logic [7:0]  tries_new;
   assign top_room  = 16'(SEG_LEN - p_rdata[10:0]);
   assign top_c     = (top_room > bytes_ff) ? bytes_ff : top_room;
   assign cut_rest  = bytes_ff - taken_ff;
   assign cut_c     = (cut_rest > 16'(SEGMENT_BYTES)) ? 16'(SEGMENT_BYTES) : cut_rest;
   assign cut_taken = taken_ff + cut_c;
   assign cut_total = 18'(buffered_ff) + 18'(cut_taken);
   assign buf_sum   = 18'(buffered_ff) + 18'(taken_ff);
   assign grow      = 17'(ws_ff) * 17'(SEGMENT_BYTES);
   assign new_limit = (grow > limit_ff) ? grow : limit_ff;
   assign send_seq  = next_seq_ff - 32'(pf_ff);
   assign tries_new = (w_rdata[18:11] == TRIES_MAX) ? TRIES_MAX : w_rdata[18:11] + 8'd1;

   // store read addresses
   assign p_raddr = (state_ff == S_TOP_RD) ? p_last : ph_ff;
   assign w_raddr = (state_ff == S_ACK_RD || state_ff == S_ACK_SUB) ? wh_ff : res_addr;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      bytes_in       = bytes_ff;
      seq_in         = seq_ff;
      final_in       = final_ff;
      now_in         = now_ff;
      taken_in       = taken_ff;
      next_seq_in    = next_seq_ff;
      sent_high_in   = sent_high_ff;
      base_in        = base_ff;
      buffered_in    = buffered_ff;
      limit_in       = limit_ff;
      pf_in          = pf_ff;
      ph_in          = ph_ff;
      wf_in          = wf_ff;
      wh_in          = wh_ff;
      res_rel_in     = res_rel_ff;
      ws_in          = ws_ff;
      nagle_en_in    = nagle_en_ff;
      nagle_delay_in = nagle_delay_ff;
      p_we           = 1'b0;
      p_waddr        = p_tail;
      p_wdata        = {now_ff, 11'(cut_c)};
      w_we           = 1'b0;
      w_waddr        = w_tail;
      w_wdata        = {8'd1, p_rdata[10:0]};
      res_push       = 1'b0;
      res_flush      = 1'b0;
      res_data       = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in  = req_tuser;
               bytes_in = in_bytes;
               seq_in   = in_seq;
               final_in = in_final;
               now_in   = in_now;
               taken_in = '0;
               case (req_tuser)
                  KIND_PUSH: state_in = (pf_ff != '0) ? S_TOP_RD : S_CUT;
                  KIND_ACK:  state_in = (sent_high_ff < in_seq) ? S_FIN : S_ACK_RD;
                  KIND_NACK: begin
                     res_rel_in = WAW'(nack_idx);
                     if (nack_hit) begin
                        state_in = S_RES_RD;
                     end else if (in_final) begin
                        state_in = (sent_high_ff < in_seq) ? S_FIN : S_ACK_RD;
                     end else begin
                        state_in = S_FIN;
                     end
                  end
                  default: state_in = S_SEND_RD;
               endcase
            end
         end
         S_TOP_RD: state_in = S_TOP;
         // top up the newest pending segment
         S_TOP: begin
            if (p_rdata[10:0] < SEG_LEN) begin
               p_we     = 1'b1;
               p_waddr  = p_last;
               p_wdata  = {p_rdata[42:11], p_rdata[10:0] + 11'(top_c)};
               taken_in = top_c;
            end
            state_in = S_CUT;
         end
         // cut one new segment per cycle
         S_CUT: begin
            if (taken_ff < bytes_ff && pf_ff < PFW'(PENDING_DEPTH)) begin
               p_we        = 1'b1;
               pf_in       = pf_ff + PFW'(1);
               next_seq_in = next_seq_ff + 32'd1;
               taken_in    = cut_taken;
               if (cut_total > 18'(limit_ff)) begin
                  state_in = S_SUM;
               end
            end else begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            buffered_in = (buf_sum > 18'(BUF_MAX)) ? BUF_MAX : 17'(buf_sum);
            state_in    = S_SEND_RD;
         end
         S_SEND_RD: begin
            if (can_move) begin
               state_in = S_SEND;
            end else begin
               state_in = (kind_ff == KIND_PUSH) ? S_ACC : S_WRIT;
            end
         end
         // move the oldest pending segment into the window
         S_SEND: begin
            if (nagle_hold) begin
               state_in = (kind_ff == KIND_PUSH) ? S_ACC : S_WRIT;
            end else if (res_ok) begin
               if (wf_ff == '0) begin
                  base_in = send_seq;
               end
               w_we    = 1'b1;
               wf_in   = wf_ff + WFW'(1);
               ph_in   = ph_next;
               pf_in   = pf_ff - PFW'(1);
               if (sent_high_ff < send_seq) begin
                  sent_high_in = send_seq;
               end
               res_push = 1'b1;
               res_data.event_res      = EV_SEND;
               res_data.out_seq        = send_seq;
               res_data.segment_length = p_rdata[10:0];
               res_data.send_count     = 8'd1;
               state_in = S_SEND_RD;
            end
         end
         S_ACC: begin
            if (res_ok) begin
               res_push = 1'b1;
               res_data.event_res      = EV_ACCEPTED;
               res_data.accepted_bytes = taken_ff;
               state_in = S_FIN;
            end
         end
         S_WRIT: begin
            if (buffered_ff >= new_limit) begin
               limit_in = new_limit;
               state_in = S_FIN;
            end else if (res_ok) begin
               limit_in = new_limit;
               res_push = 1'b1;
               res_data.event_res = EV_WRITABLE;
               state_in = S_FIN;
            end
         end
         // free acked window entries one at a time, through the read and subtract states
         S_ACK_RD: begin
            state_in = ((wf_ff != '0) && (base_ff <= seq_ff)) ? S_ACK_SUB : S_ACK_END;
         end
         S_ACK_SUB: begin
            buffered_in = (buffered_ff > 17'(w_rdata[10:0])) ?
                          buffered_ff - 17'(w_rdata[10:0]) : '0;
            wh_in    = wh_next;
            wf_in    = wf_ff - WFW'(1);
            base_in  = base_ff + 32'd1;
            state_in = S_ACK_RD;
         end
         S_ACK_END: begin
            res_rel_in = '0;
            kind_in    = KIND_ACK;
            state_in   = (wf_ff == WFW'(1)) ? S_RES_RD : S_WRIT;
         end
         S_RES_RD: state_in = S_RES;
         // resend one window entry
         S_RES: begin
            if (res_ok) begin
               w_we     = 1'b1;
               w_waddr  = res_addr;
               w_wdata  = {tries_new, w_rdata[10:0]};
               res_push = 1'b1;
               res_data.event_res      = EV_RESEND;
               res_data.out_seq        = base_ff + 32'(res_rel_ff);
               res_data.segment_length = w_rdata[10:0];
               res_data.send_count     = tries_new;
               if (kind_ff == KIND_ACK) begin
                  state_in = S_WRIT;
               end else if (final_ff) begin
                  state_in = (sent_high_ff < seq_ff) ? S_FIN : S_ACK_RD;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            if (res_ok) begin
               res_flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // configuration writes
      if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW_SIZE: ws_in = csr_data[5:0];
            CSR_NAGLE_EN:    nagle_en_in = csr_data[0];
            CSR_NAGLE_DELAY: nagle_delay_in = csr_data[15:0];
            CSR_INIT_SEQ: begin
               next_seq_in  = csr_data;
               sent_high_in = csr_data;
               base_in      = csr_data;
               buffered_in  = '0;
               pf_in        = '0;
               wf_in        = '0;
               ph_in        = '0;
               wh_in        = '0;
            end
            default: ws_in = ws_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         next_seq_ff    <= 32'd1;
         sent_high_ff   <= 32'd1;
         base_ff        <= 32'd1;
         buffered_ff    <= '0;
         limit_ff       <= 17'(DEFAULT_LIMIT);
         pf_ff          <= '0;
         ph_ff          <= '0;
         wf_ff          <= '0;
         wh_ff          <= '0;
         ws_ff          <= 6'd16;
         nagle_en_ff    <= 1'b0;
         nagle_delay_ff <= 16'd100;
      end else begin
         state_ff       <= state_in;
         next_seq_ff    <= next_seq_in;
         sent_high_ff   <= sent_high_in;
         base_ff        <= base_in;
         buffered_ff    <= buffered_in;
         limit_ff       <= limit_in;
         pf_ff          <= pf_in;
         ph_ff          <= ph_in;
         wf_ff          <= wf_in;
         wh_ff          <= wh_in;
         ws_ff          <= ws_in;
         nagle_en_ff    <= nagle_en_in;
         nagle_delay_ff <= nagle_delay_in;
      end
      kind_ff    <= kind_in;
      bytes_ff   <= bytes_in;
      seq_ff     <= seq_in;
      final_ff   <= final_in;
      now_ff     <= now_in;
      taken_ff   <= taken_in;
      res_rel_ff <= res_rel_in;
   end

   // pending store: {arrival time, length}
   rstw_ram #(.WIDTH(43), .DEPTH(PENDING_DEPTH)) u_pending (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (p_wdata),
      .rd_addr (p_raddr),
      .rd_data (p_rdata)
   );

   // window store: {tries, length}
   rstw_ram #(.WIDTH(19), .DEPTH(WINDOW_DEPTH)) u_window (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (w_waddr),
      .wr_data (w_wdata),
      .rd_addr (w_raddr),
      .rd_data (w_rdata)
   );

   rstw_out u_out (
      .clock      (clock),
      .reset      (reset),
      .res_push   (res_push),
      .res_flush  (res_flush),
      .res_data   (res_data),
      .res_ok     (res_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );
endmodule

// ===== rtl/rstw_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module rstw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== rtl/rstw_out.sv =====
// Result output stage: one hold register and one output register, so the
// final result of an item can be marked last. Depends on rstw_pkg.
module rstw_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                res_push,
   input  logic                res_flush,
   input  rstw_pkg::result_type res_data,
   output logic                res_ok,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [71:0]         rsp_tdata,   // out_seq, segment_length, send_count, accepted_bytes
   output logic [1:0]          rsp_tuser,   // event_res
   output logic                rsp_tlast
);
   import rstw_pkg::*;

   logic       hold_v_ff, hold_v_in;
   result_type hold_ff, hold_in;
   logic       out_v_ff, out_v_in;
   result_type out_ff, out_in;
   logic       last_ff, last_in;

   assign res_ok = !hold_v_ff || !out_v_ff || rsp_tready;

   // move held result out when a new one arrives or the item ends
   always_comb begin
      hold_v_in = hold_v_ff;
      hold_in   = hold_ff;
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      last_in   = last_ff;
      if (out_v_ff && rsp_tready) begin
         out_v_in = 1'b0;
      end
      if ((res_push || res_flush) && hold_v_ff) begin
         out_v_in = 1'b1;
         out_in   = hold_ff;
         last_in  = res_flush;
      end
      if (res_push) begin
         hold_v_in = 1'b1;
         hold_in   = res_data;
      end else if (res_flush) begin
         hold_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         hold_v_ff <= hold_v_in;
         out_v_ff  <= out_v_in;
      end
      hold_ff <= hold_in;
      out_ff  <= out_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = out_ff.event_res;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {5'd0, out_ff.accepted_bytes, out_ff.send_count,
                        out_ff.segment_length, out_ff.out_seq};
endmodule

// ===== test/send_window_monitor.sv =====
`timescale 1ns / 100ps
// Watching checker for the reliable send window tracker: follows the csr_, req_
// and rsp_ channels, forecasts each result and compares it. Depends on rstw_pkg.
module send_window_monitor
   import rstw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [103:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [71:0]  rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   input  logic         rsp_tlast,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data,
   output int           errors,
   output int           outstanding,
   output int           results_seen,
   output logic [31:0]  win_base,
   output int           win_fill
);

   localparam int SEG   = 1024;
   localparam int WDEP  = 32;
   localparam int PDEP  = 64;

   typedef struct {
      result_type r;
      logic       lst;
   } due_entry_type;

   due_entry_type due_results[$];
   due_entry_type item_results[$];

   // registers
   logic [5:0]  ws;
   logic        nagle_on;
   logic [15:0] nagle_ms;
   logic [31:0] first_seq;

   // forecast state
   logic [31:0] nxt_seq, high_seq, window_start;
   logic [16:0] buffered, limit;
   logic [10:0] p_len [PDEP];
   logic [31:0] p_time [PDEP];
   int          p_fill;
   logic [10:0] w_len [WDEP];
   logic [7:0]  w_tries [WDEP];
   int          w_fill;

   assign win_base = window_start;
   assign win_fill = w_fill;

   task automatic add_result(logic [1:0] ev, logic [31:0] sq, logic [10:0] len,
                             logic [7:0] cnt, logic [15:0] acc);
      due_entry_type e;
      e.r.event_res = ev;
      e.r.out_seq = sq;
      e.r.segment_length = len;
      e.r.send_count = cnt;
      e.r.accepted_bytes = acc;
      e.lst = 1'b0;
      item_results.insert(item_results.size(), e);
   endtask

   task automatic restart_tracker();
      nxt_seq = first_seq;
      high_seq = first_seq;
      window_start = first_seq;
      buffered = '0;
      p_fill = 0;
      w_fill = 0;
   endtask

   task automatic resend_entry(int idx);
      if (w_tries[idx] < TRIES_MAX) w_tries[idx] = w_tries[idx] + 8'd1;
      add_result(EV_RESEND, window_start + idx, w_len[idx], w_tries[idx], '0);
   endtask

   // move pending segments into the window, oldest first
   task automatic drain_pending(logic [31:0] now);
      int room;
      logic [31:0] sq;
      room = (ws < WDEP) ? ws : WDEP;
      while (p_fill > 0 && w_fill < room) begin
         sq = nxt_seq - p_fill;
         if (nagle_on && ({1'b0, p_time[0]} + nagle_ms > {1'b0, now}) &&
             p_len[0] < SEG - SMALL_MARGIN)
            break;
         if (w_fill == 0) window_start = sq;
         w_len[w_fill] = p_len[0];
         w_tries[w_fill] = 8'd1;
         w_fill++;
         for (int i = 0; i < p_fill - 1; i++) begin
            p_len[i] = p_len[i + 1];
            p_time[i] = p_time[i + 1];
         end
         p_fill--;
         add_result(EV_SEND, sq, w_len[w_fill - 1], 8'd1, '0);
         if (high_seq < sq) high_seq = sq;
      end
   endtask

   task automatic report_writable();
      logic [16:0] grow;
      grow = 17'(ws * SEG);
      if (grow > limit) limit = grow;
      if (buffered < limit) add_result(EV_WRITABLE, '0, '0, '0, '0);
   endtask

   task automatic apply_ack(logic [31:0] sq);
      int n;
      n = 0;
      if (high_seq < sq) return;
      if (w_fill > 0) begin
         while (n < w_fill && (window_start + n) <= sq) begin
            buffered = (buffered > w_len[n]) ? buffered - w_len[n] : '0;
            n++;
         end
         for (int i = 0; i < w_fill - n; i++) begin
            w_len[i] = w_len[i + n];
            w_tries[i] = w_tries[i + n];
         end
         w_fill -= n;
         window_start = window_start + n;
         if (w_fill == 1) resend_entry(0);
      end
      report_writable();
   endtask

   task automatic apply_push(int unsigned n, logic [31:0] now);
      int unsigned taken, c, total;
      taken = 0;
      if (p_fill > 0 && p_len[p_fill - 1] < SEG) begin
         c = SEG - p_len[p_fill - 1];
         if (c > n) c = n;
         p_len[p_fill - 1] = 11'(p_len[p_fill - 1] + c);
         taken += c;
      end
      while (taken < n && p_fill < PDEP) begin
         c = n - taken;
         if (c > SEG) c = SEG;
         p_time[p_fill] = now;
         p_len[p_fill] = 11'(c);
         p_fill++;
         nxt_seq = nxt_seq + 1;
         taken += c;
         if (buffered + taken > limit) break;
      end
      total = buffered + taken;
      buffered = (total > BUF_MAX) ? BUF_MAX : 17'(total);
      drain_pending(now);
      add_result(EV_ACCEPTED, '0, '0, '0, taken[15:0]);
   endtask

   task automatic forecast_item(logic [1:0] kind, logic [103:0] d);
      logic [31:0] idx;
      item_results.delete();
      case (kind)
         KIND_PUSH: apply_push(32'(d[15:0]), d[97:66]);
         KIND_ACK:  apply_ack(d[47:16]);
         KIND_NACK: begin
            if (d[64]) begin
               idx = d[47:16] + 32'(d[63:48]) - window_start;
               if (idx < w_fill) resend_entry(int'(idx));
            end
            if (d[65]) apply_ack(d[47:16]);
         end
         default: begin
            drain_pending(d[97:66]);
            report_writable();
         end
      endcase
      if (item_results.size() > 0) item_results[item_results.size() - 1].lst = 1'b1;
      foreach (item_results[i]) due_results.insert(due_results.size(), item_results[i]);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      due_entry_type e;
      if (reset) begin
         ws = 6'd16;
         nagle_on = 1'b0;
         nagle_ms = 16'd100;
         first_seq = 32'd1;
         limit = 17'd4096;
         restart_tracker();
         due_results.delete();
         errors = 0;
         results_seen = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WINDOW_SIZE: ws = csr_data[5:0];
               CSR_NAGLE_EN:    nagle_on = csr_data[0];
               CSR_NAGLE_DELAY: nagle_ms = csr_data[15:0];
               default: begin
                  first_seq = csr_data;
                  restart_tracker();
               end
            endcase
         end
         if (req_tvalid && req_tready) forecast_item(req_tuser, req_tdata);
         // compare each result transfer with the oldest forecast
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (due_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, actual event %0d seq %0h",
                        $time, rsp_tuser, rsp_tdata[31:0]);
            end else begin
               e = due_results[0];
               due_results.delete(0);
               check_field("event_res", 32'(e.r.event_res), 32'(rsp_tuser));
               check_field("out_seq", e.r.out_seq, rsp_tdata[31:0]);
               check_field("segment_length", 32'(e.r.segment_length),
                           32'(rsp_tdata[42:32]));
               check_field("send_count", 32'(e.r.send_count), 32'(rsp_tdata[50:43]));
               check_field("accepted_bytes", 32'(e.r.accepted_bytes),
                           32'(rsp_tdata[66:51]));
               check_field("last", 32'(e.lst), 32'(rsp_tlast));
            end
         end
      end
      outstanding = due_results.size();
   end

endmodule

// ===== test/reliable_send_window_tracker_tb.sv =====
`timescale 1ns / 100ps
// Top of the reliable send window tracker bench: clock, reset, stimulus and
// verdict. Depends on rstw_pkg, the tracker RTL and send_window_monitor.
module reliable_send_window_tracker_tb;
   import rstw_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;
   logic [1:0]   req_tuser = KIND_TICK;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [71:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = CSR_WINDOW_SIZE;
   logic [31:0]  csr_data = '0;

   int          errors, outstanding, results_seen, win_fill;
   logic [31:0] win_base;
   logic [31:0] now_ms = 32'd0;
   int          items_sent = 0;
   logic        quiet = 1'b0;
   logic        hold_rsp = 1'b0;

   reliable_send_window_tracker dut (.*);

   send_window_monitor monitor (.*);

   initial forever #1 clock = ~clock;

   // receiver: random stall bursts, a long hold-off, none when quiet
   int run_left = 0, gap_left = 0;
   always @(posedge clock) begin
      if (hold_rsp) begin
         rsp_tready <= 1'b0;
      end else if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (gap_left > 0) begin
         gap_left--;
         rsp_tready <= 1'b0;
      end else if (run_left > 0) begin
         run_left--;
         rsp_tready <= 1'b1;
      end else begin
         run_left = $urandom_range(1, 30);
         gap_left = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 12) : 0;
         rsp_tready <= 1'b1;
      end
   end

   // long receiver hold-off while items keep coming
   initial begin
      wait (items_sent == 150);
      hold_rsp = 1'b1;
      repeat (500) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic send_item(logic [1:0] kind, logic [15:0] bc, logic [31:0] sq,
                            logic [15:0] off, logic hl, logic fe);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {6'd0, now_ms, fe, hl, off, sq, bc};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      items_sent++;
   endtask

   // wait for every forecast result, then for the sequencer to settle
   task automatic settle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_mode(logic [5:0] ws, logic ng, logic [15:0] dly, logic [31:0] seq0);
      settle();
      csr_write(CSR_WINDOW_SIZE, 32'(ws));
      csr_write(CSR_NAGLE_EN, 32'(ng));
      csr_write(CSR_NAGLE_DELAY, 32'(dly));
      csr_write(CSR_INIT_SEQ, seq0);
   endtask

   // mostly well-formed traffic around the current window, some noise
   task automatic random_items(int count);
      int unsigned pick;
      logic [15:0] bc, off;
      logic [31:0] sq;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         now_ms = now_ms + $urandom_range(0, 40);
         bc = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 1500));
         sq = $urandom;
         off = 16'($urandom);
         if (pick < 40) begin
            send_item(KIND_PUSH, bc, sq, off, 1'($urandom), 1'($urandom));
         end else if (pick < 65) begin
            if ($urandom_range(0, 9) != 0) sq = win_base + $urandom_range(0, win_fill) - 1;
            send_item(KIND_ACK, bc, sq, off, 1'($urandom), 1'($urandom));
         end else if (pick < 85) begin
            if ($urandom_range(0, 9) != 0) begin
               sq = win_base - $urandom_range(0, 2);
               off = 16'($urandom_range(0, win_fill + 2));
            end
            send_item(KIND_NACK, bc, sq, off, $urandom_range(0, 9) != 0, 1'($urandom));
         end else begin
            send_item(KIND_TICK, bc, sq, off, 1'($urandom), 1'($urandom));
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, sizes at the extremes, every kind
      send_item(KIND_PUSH, 16'd0, '0, '0, 1'b0, 1'b0);
      send_item(KIND_PUSH, 16'd1, '0, '0, 1'b0, 1'b0);
      send_item(KIND_PUSH, 16'd1023, '0, '0, 1'b0, 1'b0);
      send_item(KIND_PUSH, 16'hffff, '1, '1, 1'b1, 1'b1);
      send_item(KIND_TICK, '0, '0, '0, 1'b0, 1'b0);
      send_item(KIND_ACK, '0, 32'hffff_ffff, '0, 1'b0, 1'b0);
      send_item(KIND_NACK, '0, win_base, 16'd1, 1'b1, 1'b0);
      send_item(KIND_NACK, '0, win_base, 16'd0, 1'b0, 1'b0);
      send_item(KIND_NACK, '0, win_base, 16'hffff, 1'b1, 1'b0);
      send_item(KIND_NACK, '0, win_base, 16'd0, 1'b1, 1'b1);
      send_item(KIND_ACK, '0, win_base + win_fill - 2, '0, 1'b0, 1'b0);
      send_item(KIND_ACK, '0, win_base + win_fill - 1, '0, 1'b0, 1'b0);
      send_item(KIND_NACK, '0, win_base - 1, 16'd0, 1'b0, 1'b1);
      send_item(KIND_PUSH, 16'd700, '0, '0, 1'b0, 1'b0);
      send_item(KIND_PUSH, 16'd300, '0, '0, 1'b0, 1'b0);
      send_item(KIND_TICK, '0, '0, '0, 1'b0, 1'b0);

      // zero window: nothing sent, buffer fills
      set_mode(6'd0, 1'b0, 16'd0, 32'd5);
      send_item(KIND_PUSH, 16'd5000, '0, '0, 1'b0, 1'b0);
      send_item(KIND_PUSH, 16'd1, '0, '0, 1'b0, 1'b0);
      send_item(KIND_TICK, '0, '0, '0, 1'b0, 1'b0);
      send_item(KIND_ACK, '0, 32'd5, '0, 1'b0, 1'b0);
      random_items(16);

      // full window with sequences wrapping through zero
      set_mode(6'd32, 1'b0, 16'd100, 32'hffff_fff0);
      random_items(110);

      // small window with Nagle holding back young segments
      set_mode(6'd4, 1'b1, 16'd50, $urandom);
      now_ms = $urandom;
      random_items(90);

      // window register above the depth, longest Nagle delay
      set_mode(6'd63, 1'b1, 16'hffff, 32'hffff_ffff);
      now_ms = 32'hffff_ff00;
      random_items(60);

      // single entry window, then steady traffic with no stalls
      set_mode(6'd1, 1'b0, 16'd0, 32'h8000_0000);
      random_items(60);
      quiet = 1'b1;
      random_items(50);

      settle();
      $display("covered %0d items and %0d results over six window settings",
               items_sent, results_seen);
      if (errors == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
